>>> rtl/dbc_pkg.sv
// Shared types and constants for the button matrix debouncer.
// No dependencies; imported by every module of the block.
package dbc_pkg;

  localparam int MaxRows = 3;
  localparam int MaxCols = 8;
  localparam int CntW    = 4;
  localparam int ColW    = 4;
  localparam int EdgeW   = MaxRows * MaxCols;

  localparam logic [ColW-1:0] NoneCol    = 4'd8;
  localparam logic [CntW-1:0] LimitReset = 4'd5;

  typedef enum logic {
    OpScan  = 1'b0,
    OpClear = 1'b1
  } op_e;

  // One memory word: all counters and pressed flags of one row.
  typedef struct packed {
    logic [MaxCols-1:0][CntW-1:0] cnt;
    logic [MaxCols-1:0]           pressed;
  } row_state_t;

  // Updated row state plus the transitions of this tick.
  typedef struct packed {
    row_state_t         state;
    logic [MaxCols-1:0] press_edge;
    logic [MaxCols-1:0] rel_edge;
  } row_upd_t;

endpackage

>>> rtl/dbc_row_mem.sv
// Row state memory: one word per row, registered read, write-to-read forwarding.
// Valid bits make unwritten rows read as all zero. Depends on dbc_pkg.
module dbc_row_mem #(
  parameter int DEPTH = 3,
  parameter int AW    = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output dbc_pkg::row_state_t rdata_o,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  dbc_pkg::row_state_t wdata_i
);
  import dbc_pkg::*;

  row_state_t       mem_q [DEPTH];
  row_state_t       rd_data_q;
  logic [DEPTH-1:0] vld_q;
  logic             rd_ok_q;
  logic             same_addr;

  assign same_addr = we_i && (waddr_i == raddr_i);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_data_q <= same_addr ? wdata_i : mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_ok_q <= vld_q[raddr_i] || same_addr;
      end
    end
  end

  assign rdata_o = rd_ok_q ? rd_data_q : '0;

endmodule

>>> rtl/dbc_row_update.sv
// Integrating counter update for one row of buttons, plus edge detection.
// Purely combinational. Depends on dbc_pkg.
module dbc_row_update (
  input  dbc_pkg::row_state_t                  state_i,
  input  logic [dbc_pkg::MaxCols-1:0]          raw_i,
  input  logic [dbc_pkg::CntW-1:0]             limit_i,
  input  logic [dbc_pkg::MaxCols-1:0]          col_en_i,
  output dbc_pkg::row_upd_t                    upd_o
);
  import dbc_pkg::*;

  always_comb begin
    logic [CntW:0]   inc;
    logic [CntW-1:0] cnt;
    upd_o = '0;
    upd_o.state = state_i;
    for (int c = 0; c < MaxCols; c++) begin
      inc = {1'b0, state_i.cnt[c]} + (CntW+1)'(1);
      if (!raw_i[c]) begin
        // button down: count up, clamp at limit (also pulls down a stale high count)
        cnt = (inc > {1'b0, limit_i}) ? limit_i : inc[CntW-1:0];
      end else if (state_i.cnt[c] != '0) begin
        cnt = state_i.cnt[c] - CntW'(1);
      end else begin
        cnt = '0;
      end
      if (col_en_i[c]) begin
        upd_o.state.cnt[c] = cnt;
        if (cnt == limit_i) begin
          upd_o.press_edge[c]    = !state_i.pressed[c];
          upd_o.state.pressed[c] = 1'b1;
        end else if (cnt == '0) begin
          upd_o.rel_edge[c]      = state_i.pressed[c];
          upd_o.state.pressed[c] = 1'b0;
        end
      end
    end
  end

endmodule

>>> rtl/button_matrix_debouncer.sv
// Button matrix debouncer: top level with row sequencer and result assembly.
// Depends on dbc_pkg, dbc_row_mem and dbc_row_update.
//
// Each input transfer carries one scan tick (raw active-low levels of every
// row) or a clear of the last-pressed record. Every button has a 4-bit
// integrating counter that counts up while the pin is low and down while it
// is high, saturating at 0 and at debounce_limit (0 acts as 1); reaching the
// limit marks the button pressed, reaching 0 marks it released. Counters and
// pressed flags live in a small synchronous memory, one word per row. An item
// is walked row by row: each row word is read from the memory, then updated
// and written back, and the row results are gathered for the output
// register; a new item is taken as soon as the last row of the last one is
// read. The output register decouples the sides: a new item is taken while a
// finished result waits. The limit register may only be written while the
// block is idle. Reset clears the memory through per-row valid bits, so no
// clearing pass is needed.
module button_matrix_debouncer #(
  parameter int ROWS    = 3,
  parameter int COLUMNS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [dbc_pkg::CntW-1:0]     cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [dbc_pkg::MaxCols-1:0]  row0_raw_i,
  input  logic [dbc_pkg::MaxCols-1:0]  row1_raw_i,
  input  logic [dbc_pkg::MaxCols-1:0]  row2_raw_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [dbc_pkg::MaxCols-1:0]  row0_pressed_o,
  output logic [dbc_pkg::MaxCols-1:0]  row1_pressed_o,
  output logic [dbc_pkg::MaxCols-1:0]  row2_pressed_o,
  output logic [dbc_pkg::ColW-1:0]     row0_count_o,
  output logic [dbc_pkg::ColW-1:0]     row1_count_o,
  output logic [dbc_pkg::ColW-1:0]     row2_count_o,
  output logic [dbc_pkg::ColW-1:0]     row0_last_o,
  output logic [dbc_pkg::ColW-1:0]     row1_last_o,
  output logic [dbc_pkg::ColW-1:0]     row2_last_o,
  output logic                         new_press_o,
  output logic [dbc_pkg::EdgeW-1:0]    press_edges_o,
  output logic [dbc_pkg::EdgeW-1:0]    release_edges_o
);
  import dbc_pkg::*;

  localparam int RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [MaxCols-1:0] ColMask = MaxCols'((1 << COLUMNS) - 1);

  // ---------------------------------------------------------------------
  // Debounce limit register
  // ---------------------------------------------------------------------
  logic [CntW-1:0] limit_q;
  logic [CntW-1:0] limit_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  assign limit_eff = (limit_q == '0) ? CntW'(1) : limit_q;

  // ---------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------
  logic            s1_valid_q;
  logic [RowW-1:0] rd_row_q;
  logic            s1_op_q;
  logic [MaxCols-1:0] s1_raw_q [MaxRows];
  logic            s1_last;

  logic            s2_valid_q;
  logic [RowW-1:0] s2_row_q;
  logic            s2_op_q;
  logic [MaxCols-1:0] s2_raw_q;
  logic            s2_last;

  logic            out_valid_q;
  logic            adv;
  logic            in_acc;
  logic            out_load;

  assign s1_last  = (rd_row_q == RowW'(ROWS - 1));
  assign s2_last  = (s2_row_q == RowW'(ROWS - 1));
  // Everything freezes only when a finished item cannot enter the output reg.
  assign adv      = !(s2_valid_q && s2_last && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !(adv && s1_last);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = adv && s2_valid_q && s2_last;

  // Stage 1: hold the item, issue one row read per cycle while the pipeline advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      rd_row_q   <= '0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
      rd_row_q   <= '0;
    end else if (adv && s1_valid_q) begin
      if (s1_last) begin
        s1_valid_q <= 1'b0;
      end else begin
        rd_row_q <= rd_row_q + RowW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q     <= operation_i;
      s1_raw_q[0] <= row0_raw_i;
      s1_raw_q[1] <= row1_raw_i;
      s1_raw_q[2] <= row2_raw_i;
    end
  end

  // Stage 2: row word arrives from memory, update and write back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_row_q   <= '0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        s2_row_q <= rd_row_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      s2_op_q  <= s1_op_q;
      s2_raw_q <= s1_raw_q[rd_row_q];
    end
  end

  // ---------------------------------------------------------------------
  // Row state memory and counter update
  // ---------------------------------------------------------------------
  row_state_t rd_state;
  row_upd_t   upd;
  logic       is_scan;
  logic       mem_we;

  assign is_scan = (s2_op_q == OpScan);
  assign mem_we  = adv && s2_valid_q && is_scan;

  dbc_row_mem #(
    .DEPTH (ROWS),
    .AW    (RowW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (adv && s1_valid_q),
    .raddr_i (rd_row_q),
    .rdata_o (rd_state),
    .we_i    (mem_we),
    .waddr_i (s2_row_q),
    .wdata_i (upd.state)
  );

  dbc_row_update u_upd (
    .state_i  (rd_state),
    .raw_i    (s2_raw_q),
    .limit_i  (limit_eff),
    .col_en_i (ColMask),
    .upd_o    (upd)
  );

  // ---------------------------------------------------------------------
  // Last-pressed record and per-row result assembly
  // ---------------------------------------------------------------------
  logic [ColW-1:0]    last_q [MaxRows];
  logic [MaxCols-1:0] cur_mask, cur_press, cur_rel;
  logic [ColW-1:0]    cur_cnt, cur_last;

  logic [MaxCols-1:0] acc_pressed_q [MaxRows];
  logic [ColW-1:0]    acc_count_q   [MaxRows];
  logic [ColW-1:0]    acc_last_q    [MaxRows];
  logic [EdgeW-1:0]   acc_pe_q, acc_re_q;
  logic [MaxCols-1:0] acc_pressed_d [MaxRows];
  logic [ColW-1:0]    acc_count_d   [MaxRows];
  logic [ColW-1:0]    acc_last_d    [MaxRows];
  logic [EdgeW-1:0]   acc_pe_d, acc_re_d;

  always_comb begin
    // a clear reports the stored mask untouched and no transitions
    cur_mask  = is_scan ? upd.state.pressed : rd_state.pressed;
    cur_press = is_scan ? upd.press_edge : '0;
    cur_rel   = is_scan ? upd.rel_edge : '0;
    cur_cnt   = '0;
    for (int c = 0; c < MaxCols; c++) begin
      cur_cnt = cur_cnt + ColW'(cur_mask[c]);
    end
    if (!is_scan) begin
      cur_last = NoneCol;
    end else begin
      cur_last = last_q[s2_row_q];
      for (int c = 0; c < MaxCols; c++) begin
        if (cur_press[c]) begin
          cur_last = ColW'(c);  // highest column wins
        end
      end
    end
  end

  always_comb begin
    acc_pressed_d = acc_pressed_q;
    acc_count_d   = acc_count_q;
    acc_last_d    = acc_last_q;
    acc_pressed_d[s2_row_q] = cur_mask;
    acc_count_d[s2_row_q]   = cur_cnt;
    acc_last_d[s2_row_q]    = cur_last;
    acc_pe_d = ((s2_row_q == '0) ? '0 : acc_pe_q)
             | (EdgeW'(cur_press) << (s2_row_q * COLUMNS));
    acc_re_d = ((s2_row_q == '0) ? '0 : acc_re_q)
             | (EdgeW'(cur_rel) << (s2_row_q * COLUMNS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MaxRows; r++) begin
        last_q[r] <= NoneCol;
      end
    end else if (adv && s2_valid_q) begin
      last_q[s2_row_q] <= cur_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      acc_pressed_q <= acc_pressed_d;
      acc_count_q   <= acc_count_d;
      acc_last_q    <= acc_last_d;
      acc_pe_q      <= acc_pe_d;
      acc_re_q      <= acc_re_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [MaxCols-1:0] out_pressed_q [MaxRows];
  logic [ColW-1:0]    out_count_q   [MaxRows];
  logic [ColW-1:0]    out_last_q    [MaxRows];
  logic [EdgeW-1:0]   out_pe_q, out_re_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int r = 0; r < MaxRows; r++) begin
        // rows beyond ROWS report empty
        out_pressed_q[r] <= (r < ROWS) ? acc_pressed_d[r] : '0;
        out_count_q[r]   <= (r < ROWS) ? acc_count_d[r] : '0;
        out_last_q[r]    <= (r < ROWS) ? acc_last_d[r] : NoneCol;
      end
      out_pe_q <= acc_pe_d;
      out_re_q <= acc_re_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign row0_pressed_o  = out_pressed_q[0];
  assign row1_pressed_o  = out_pressed_q[1];
  assign row2_pressed_o  = out_pressed_q[2];
  assign row0_count_o    = out_count_q[0];
  assign row1_count_o    = out_count_q[1];
  assign row2_count_o    = out_count_q[2];
  assign row0_last_o     = out_last_q[0];
  assign row1_last_o     = out_last_q[1];
  assign row2_last_o     = out_last_q[2];
  assign new_press_o     = |out_pe_q;
  assign press_edges_o   = out_pe_q;
  assign release_edges_o = out_re_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Rows of one item go through stage 2 in order, one per advancing cycle.
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !s2_last && adv |=> s2_valid_q && (s2_row_q == $past(s2_row_q) + RowW'(1)))
    else $error("row sequence broken");

  // A button cannot press and release on the same tick.
  a_edges_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((press_edges_o & release_edges_o) == '0))
    else $error("press and release edges overlap");

  // No memory write while the pipeline is frozen.
  a_frozen_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && s2_valid_q && s2_last) |-> !mem_we)
    else $error("row write while stalled");

  // A stalled output item keeps its edge masks.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_pe_q) && $stable(out_re_q))
    else $error("stalled result changed");

endmodule

>>> tb/sv/dbc_checker.sv
// Scoreboard for the button matrix debouncer: predicts every scan result and
// compares it with the block's output transfers. Depends on dbc_pkg.
module dbc_checker #(
  parameter int ROWS    = 3,
  parameter int COLUMNS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dbc_pkg::CntW-1:0]     cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         operation_i,
  input  logic [dbc_pkg::MaxCols-1:0]  row0_raw_i,
  input  logic [dbc_pkg::MaxCols-1:0]  row1_raw_i,
  input  logic [dbc_pkg::MaxCols-1:0]  row2_raw_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [dbc_pkg::MaxCols-1:0]  row0_pressed_i,
  input  logic [dbc_pkg::MaxCols-1:0]  row1_pressed_i,
  input  logic [dbc_pkg::MaxCols-1:0]  row2_pressed_i,
  input  logic [dbc_pkg::ColW-1:0]     row0_count_i,
  input  logic [dbc_pkg::ColW-1:0]     row1_count_i,
  input  logic [dbc_pkg::ColW-1:0]     row2_count_i,
  input  logic [dbc_pkg::ColW-1:0]     row0_last_i,
  input  logic [dbc_pkg::ColW-1:0]     row1_last_i,
  input  logic [dbc_pkg::ColW-1:0]     row2_last_i,
  input  logic                         new_press_i,
  input  logic [dbc_pkg::EdgeW-1:0]    press_edges_i,
  input  logic [dbc_pkg::EdgeW-1:0]    release_edges_i,
  output int unsigned                  pending_o,
  output int unsigned                  fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dbc_pkg::*;

  typedef struct packed {
    logic [MaxRows-1:0][MaxCols-1:0] pressed;
    logic [MaxRows-1:0][ColW-1:0]    count;
    logic [MaxRows-1:0][ColW-1:0]    last;
    logic                            new_press;
    logic [EdgeW-1:0]                press_edges;
    logic [EdgeW-1:0]                release_edges;
  } scan_result_t;

  // predictor state
  logic [CntW-1:0] integ_q   [MaxRows][MaxCols];
  logic            held_q    [MaxRows][MaxCols];
  logic [ColW-1:0] last_col_q[MaxRows];
  logic [CntW-1:0] limit_q;

  scan_result_t scan_results_q[$];
  scan_result_t seen;
  scan_result_t wanted;
  int unsigned  err_cnt;

  function automatic scan_result_t debounce_tick(input op_e op,
                                                 input logic [EdgeW-1:0] raw);
    scan_result_t    res;
    logic [CntW-1:0] lim;
    int unsigned     cnt;
    int unsigned     npress;
    res = '0;
    lim = (limit_q == '0) ? CntW'(1) : limit_q;
    if (op == OpClear) begin
      for (int r = 0; r < MaxRows; r++) last_col_q[r] = NoneCol;
    end else begin
      for (int r = 0; r < ROWS && r < MaxRows; r++) begin
        for (int c = 0; c < COLUMNS && c < MaxCols; c++) begin
          cnt = integ_q[r][c];
          if (!raw[r*MaxCols+c]) begin
            cnt++;
            if (cnt > lim) cnt = lim;
          end else if (cnt > 0) begin
            cnt--;
          end
          integ_q[r][c] = CntW'(cnt);
          if (cnt == lim) begin
            if (!held_q[r][c]) begin
              res.press_edges[r*COLUMNS+c] = 1'b1;
              last_col_q[r] = ColW'(c);
            end
            held_q[r][c] = 1'b1;
          end else if (cnt == 0) begin
            if (held_q[r][c]) res.release_edges[r*COLUMNS+c] = 1'b1;
            held_q[r][c] = 1'b0;
          end
        end
      end
    end
    for (int r = 0; r < MaxRows; r++) begin
      res.last[r] = NoneCol;
      if (r < ROWS) begin
        npress = 0;
        for (int c = 0; c < COLUMNS && c < MaxCols; c++) begin
          res.pressed[r][c] = held_q[r][c];
          if (held_q[r][c]) npress++;
        end
        res.count[r] = ColW'(npress);
        res.last[r]  = last_col_q[r];
      end
    end
    res.new_press = |res.press_edges;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [EdgeW-1:0] got,
                             input logic [EdgeW-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MaxRows; r++) begin
        for (int c = 0; c < MaxCols; c++) begin
          integ_q[r][c] = '0;
          held_q[r][c]  = 1'b0;
        end
        last_col_q[r] = NoneCol;
      end
      limit_q = LimitReset;
      scan_results_q.delete();
      err_cnt = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        scan_results_q.push_back(debounce_tick(op_e'(operation_i),
                                               {row2_raw_i, row1_raw_i, row0_raw_i}));
      if (out_valid_i && !out_stall_i) begin
        seen.pressed       = {row2_pressed_i, row1_pressed_i, row0_pressed_i};
        seen.count         = {row2_count_i, row1_count_i, row0_count_i};
        seen.last          = {row2_last_i, row1_last_i, row0_last_i};
        seen.new_press     = new_press_i;
        seen.press_edges   = press_edges_i;
        seen.release_edges = release_edges_i;
        if (scan_results_q.size() == 0) begin
          report_mismatch("result transfer with no prediction pending");
        end else begin
          wanted = scan_results_q.pop_front();
          for (int r = 0; r < MaxRows; r++) begin
            check_field($sformatf("row%0d pressed", r), seen.pressed[r], wanted.pressed[r]);
            check_field($sformatf("row%0d count", r), seen.count[r], wanted.count[r]);
            check_field($sformatf("row%0d last", r), seen.last[r], wanted.last[r]);
          end
          check_field("new_press", seen.new_press, wanted.new_press);
          check_field("press_edges", seen.press_edges, wanted.press_edges);
          check_field("release_edges", seen.release_edges, wanted.release_edges);
        end
      end
      pending_o    <= scan_results_q.size();
      fail_count_o <= err_cnt;
    end
  end

endmodule

>>> tb/sv/tb_button_matrix_debouncer.sv
// Top of the debouncer testbench: clock, reset, stimulus and verdict.
// Depends on dbc_pkg, dbc_checker and the button_matrix_debouncer RTL.
module tb_button_matrix_debouncer;
  timeunit 1ns;
  timeprecision 1ps;
  import dbc_pkg::*;

  localparam int ROWS          = 3;
  localparam int COLUMNS       = 8;
  localparam int ResetCycles   = 3;
  localparam int RandomPhases  = 6;
  localparam int PhaseItems    = 200;
  localparam int HoldOffCycles = 120;  // long receiver hold-off, fills the block
  localparam int SettleCycles  = 10;
  localparam int WatchdogLimit = 3000; // cycles without any transfer

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CntW-1:0]  cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  op_e              operation;
  logic [MaxCols-1:0] row0_raw, row1_raw, row2_raw;
  logic             out_valid;
  logic             out_stall;
  logic [MaxCols-1:0] row0_pressed, row1_pressed, row2_pressed;
  logic [ColW-1:0]  row0_count, row1_count, row2_count;
  logic [ColW-1:0]  row0_last, row1_last, row2_last;
  logic             new_press;
  logic [EdgeW-1:0] press_edges, release_edges;

  int unsigned pending;
  int unsigned fail_count;

  // Handshake shaping, owned by the stimulus process.
  bit idle_en;   // random gaps/stalls allowed
  bit hold_req;  // ask the receiver for one long hold-off

  button_matrix_debouncer #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .row0_raw_i      (row0_raw),
    .row1_raw_i      (row1_raw),
    .row2_raw_i      (row2_raw),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .row0_pressed_o  (row0_pressed),
    .row1_pressed_o  (row1_pressed),
    .row2_pressed_o  (row2_pressed),
    .row0_count_o    (row0_count),
    .row1_count_o    (row1_count),
    .row2_count_o    (row2_count),
    .row0_last_o     (row0_last),
    .row1_last_o     (row1_last),
    .row2_last_o     (row2_last),
    .new_press_o     (new_press),
    .press_edges_o   (press_edges),
    .release_edges_o (release_edges)
  );

  dbc_checker #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .operation_i     (operation),
    .row0_raw_i      (row0_raw),
    .row1_raw_i      (row1_raw),
    .row2_raw_i      (row2_raw),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .row0_pressed_i  (row0_pressed),
    .row1_pressed_i  (row1_pressed),
    .row2_pressed_i  (row2_pressed),
    .row0_count_i    (row0_count),
    .row1_count_i    (row1_count),
    .row2_count_i    (row2_count),
    .row0_last_i     (row0_last),
    .row1_last_i     (row1_last),
    .row2_last_i     (row2_last),
    .new_press_i     (new_press),
    .press_edges_i   (press_edges),
    .release_edges_i (release_edges),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // One input transfer. Entered and left at a falling edge; valid is only
  // dropped for a gap, never lowered and raised in the same step, and the
  // payload holds until the block takes it.
  task automatic send_scan(input op_e op, input logic [EdgeW-1:0] raw);
    if (idle_en && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    operation <= op;
    row0_raw  <= raw[7:0];
    row1_raw  <= raw[15:8];
    row2_raw  <= raw[23:16];
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every predicted result has been taken.
  // The first edge lets the checker's count catch up with the last transfer.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Limit writes happen only with the block idle, i.e. after wait_drained.
  task automatic write_limit(input logic [CntW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Random phase: each button follows a held/not-held level that flips now
  // and then, with contact bounce on top, so counters climb to the limit and
  // fall back. A few ticks are pure noise and a few are clears.
  task automatic run_random_phase(input int items, input int span);
    logic [EdgeW-1:0] holding;
    logic [EdgeW-1:0] raw;
    int               sel;
    holding = '0;
    for (int n = 0; n < items; n++) begin
      sel = $urandom_range(99);
      raw = EdgeW'($urandom);
      if (sel < 4) begin
        send_scan(OpClear, raw);
      end else if (sel < 10) begin
        send_scan(OpScan, raw);
      end else begin
        for (int b = 0; b < EdgeW; b++) begin
          if ($urandom_range(span - 1) == 0) holding[b] = ~holding[b];
          // pins are active low; roughly one sample in ten bounces
          raw[b] = ~holding[b] ^ ($urandom_range(9) == 0);
        end
        send_scan(OpScan, raw);
      end
    end
  endtask

  // Receiver: random stall bursts with quiet stretches between,
  // and one long hold-off on request while the sender keeps offering.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(negedge clk_i);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (idle_en && $urandom_range(4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(7, 1)) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    logic [CntW-1:0] phase_limit;
    int              span;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = LimitReset;
    in_valid  = 1'b0;
    operation = OpScan;
    row0_raw  = '1;
    row1_raw  = '1;
    row2_raw  = '1;
    idle_en   = 1'b1;
    hold_req  = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset limit: a clear on the fresh state, then all buttons down until
    // pressed (several presses in one row, the highest column wins).
    send_scan(OpClear, EdgeW'($urandom));
    repeat (5) send_scan(OpScan, '0);
    // clear forgets last columns, masks and counts stay
    send_scan(OpClear, EdgeW'($urandom));
    repeat (5) send_scan(OpScan, '1);

    // Zero limit acts as one: single down tick presses.
    wait_drained();
    write_limit('0);
    send_scan(OpScan, {8'h3C, 8'hA5, 8'h5A});
    send_scan(OpScan, '1);

    // Limit lowered under fully charged counters.
    wait_drained();
    write_limit(4'd3);
    repeat (3) send_scan(OpScan, '0);
    wait_drained();
    write_limit(4'd1);
    send_scan(OpScan, '1);  // 3 -> 2, still held
    send_scan(OpScan, '0);  // clamps down to the new limit
    send_scan(OpScan, '1);  // reaches zero, released
    send_scan(OpScan, '1);
    send_scan(OpScan, {8'h7F, 8'hEF, 8'hFE});  // single presses, col 7/4/0

    // Random phases: the top and bottom limits first, then a middle one and random ones.
    for (int p = 0; p < RandomPhases; p++) begin
      unique case (p)
        0: begin
          phase_limit = 4'd15;
        end
        1: begin
          phase_limit = 4'd1;  // lowered from 15
        end
        2: begin
          phase_limit = 4'd0;
        end
        3: begin
          phase_limit = 4'd7;
        end
        default: begin
          phase_limit = CntW'($urandom_range(15));
        end
      endcase
      wait_drained();
      write_limit(phase_limit);
      if (p == 1) hold_req = 1'b1;               // backpressure phase
      if (p == RandomPhases - 1) idle_en = 1'b0;  // last part runs flat out
      span = 3 * int'(phase_limit) + 10;
      run_random_phase(PhaseItems, span);
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
